@@ hw/rtl/sida_pkg.sv @@
// Shared types and constants for the signed integer to decimal ASCII converter.
// Used by sida_ctrl, sida_datapath and the top level; no dependencies.
package sida_pkg;

	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned CHAR_W    = 7;
	localparam int unsigned DIGIT_W   = 4;
	localparam int unsigned MAX_DIGITS = 10;
	localparam int unsigned DIG_IDX_W = 4;
	localparam int unsigned RECIP_SHIFT = 35;

	localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
	localparam logic [VALUE_W-1:0] RADIX      = 32'd10;
	// ceil(2^35 / 10): floor(x * RECIP >> 35) == x / 10 for every 32-bit x
	localparam logic [VALUE_W-1:0] RECIP      = 32'hCCCC_CCCD;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic pop;
		logic sel_minus;
	} cmd_t;

	typedef struct packed {
		logic lt_radix;
		logic neg;
		logic last;
	} sts_t;

endpackage

@@ hw/rtl/sida_datapath.sv @@
// Datapath: magnitude register, divide-by-ten step, digit buffer and character select.
// Depends on sida_pkg.
module sida_datapath import sida_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [VALUE_W-1:0] value,
	input  cmd_t               cmd,
	output sts_t               sts,
	output logic [CHAR_W-1:0]  character
);

	logic [VALUE_W-1:0]   mag_q;
	logic                 neg_q;
	logic [DIG_IDX_W-1:0] ndig_q;
	logic [DIGIT_W-1:0]   digits_q [0:MAX_DIGITS-1];

	logic [2*VALUE_W-1:0] prod;
	logic [VALUE_W-1:0]   quot;
	logic [VALUE_W-1:0]   rem;
	logic [DIG_IDX_W-1:0] rd_idx;

	assign prod   = {{VALUE_W{1'b0}}, mag_q} * {{VALUE_W{1'b0}}, RECIP};
	assign quot   = {{RECIP_SHIFT-VALUE_W{1'b0}}, prod[2*VALUE_W-1:RECIP_SHIFT]};
	assign rem    = mag_q - (quot << 3) - (quot << 1);
	assign rd_idx = ndig_q - DIG_IDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q  <= 1'b0;
			ndig_q <= '0;
		end else if (cmd.load) begin
			neg_q  <= value[VALUE_W-1];
			ndig_q <= '0;
		end else if (cmd.step) begin
			ndig_q <= ndig_q + DIG_IDX_W'(1);
		end else if (cmd.pop) begin
			ndig_q <= rd_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
		end else if (cmd.step) begin
			mag_q            <= quot;
			digits_q[ndig_q] <= rem[DIGIT_W-1:0];
		end
	end

	assign sts.lt_radix = (mag_q < RADIX);
	assign sts.neg      = neg_q;
	assign sts.last     = (ndig_q == DIG_IDX_W'(1));

	assign character = cmd.sel_minus ? ASCII_MINUS
	                                 : ASCII_ZERO + {3'b000, digits_q[rd_idx]};

endmodule

@@ hw/rtl/sida_ctrl.sv @@
// Controller FSM: sequences load, digit extraction and character transfer.
// Depends on sida_pkg.
module sida_ctrl import sida_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_valid,
	input  logic m_ready,
	input  sts_t sts,
	output logic s_ready,
	output logic m_valid,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_valid) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (sts.lt_radix) state_d = sts.neg ? ST_SIGN : ST_EMIT;
			end
			ST_SIGN: begin
				if (m_ready) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (m_ready && sts.last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_ready       = 1'b0;
		m_valid       = 1'b0;
		cmd           = '0;
		case (state_q)
			ST_IDLE: begin
				s_ready  = 1'b1;
				cmd.load = s_valid;
			end
			ST_CONV: begin
				cmd.step = 1'b1;
			end
			ST_SIGN: begin
				m_valid       = 1'b1;
				cmd.sel_minus = 1'b1;
			end
			ST_EMIT: begin
				m_valid = 1'b1;
				cmd.pop = m_ready;
			end
			default: begin
				s_ready = 1'b0;
			end
		endcase
	end

endmodule

@@ hw/rtl/signed_int_to_decimal_ascii_top.sv @@
// Converts a signed 32-bit integer into its decimal ASCII text, one character per
// transfer, most significant first; a negative value is preceded by '-' and the last
// character carries tlast. A number is loaded, then the divide-by-ten loop extracts one
// decimal digit (1 to 10) per cycle, then the characters (1 to 11) are sent on the
// output; the next number is accepted after the last character is taken.
// Depends on sida_pkg, sida_ctrl and sida_datapath.
module signed_int_to_decimal_ascii_top import sida_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [6:0] character, [7] zero
	output logic        m_axis_tlast    // final_char
);

	cmd_t              cmd;
	sts_t              sts;
	logic [CHAR_W-1:0] character;

	sida_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.m_ready (m_axis_tready),
		.sts     (sts),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.cmd     (cmd)
	);

	sida_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.character (character)
	);

	assign m_axis_tdata = {1'b0, character};
	assign m_axis_tlast = sts.last && !cmd.sel_minus;

endmodule
